// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the block allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, codes and controller/datapath interface types of the
// bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Pool geometry.
    localparam int MAX_BLOCKS   = 256;
    localparam int ADDRESS_WIDTH = 32;
    localparam int GROUP        = 8;
    localparam int WORD_W       = GROUP;
    localparam int WORDS        = MAX_BLOCKS / GROUP;
    localparam int WIDX_W       = $clog2(WORDS);
    localparam int PTR_W        = WIDX_W + 1;
    localparam int BIT_W        = $clog2(GROUP);
    localparam int IDX_W        = $clog2(MAX_BLOCKS);

    // Field and register widths.
    localparam int ADDR_W       = ADDRESS_WIDTH;
    localparam int SIZE_W       = 16;
    localparam int COUNT_W      = 9;
    localparam int NWR_W        = COUNT_W + 1 - BIT_W;
    localparam int PROD_W       = SIZE_W + PTR_W + BIT_W;
    localparam int REM_W        = SIZE_W + IDX_W;
    localparam int STEP_W       = $clog2(IDX_W);
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic scan_step;
        logic take;
        logic no_free;
        logic mul_addr;
        logic range_flag;
        logic div_start;
        logic div_step;
        logic set_bit;
        logic not_all_free;
        logic result_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic kind;
        logic word_hit;
        logic word_full;
        logic ptr_end;
        logic range_err;
        logic div_last;
    } dp_status_t;

endpackage

// ----- rtl/core/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller state machine: sequences the bitmap scan, the address multiply,
// the index divide and the result hand-off of one transaction at a time.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE       = 8'b0000_0001,
        ST_ALLOC_SCAN = 8'b0000_0010,
        ST_ALLOC_MUL  = 8'b0000_0100,
        ST_FREE_CHECK = 8'b0000_1000,
        ST_FREE_DIV   = 8'b0001_0000,
        ST_FREE_SET   = 8'b0010_0000,
        ST_FLAG_SCAN  = 8'b0100_0000,
        ST_FINISH     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Next-state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ALLOC_SCAN;
                end
            end
            ST_ALLOC_SCAN: begin
                // A fresh transaction lands here first; a free branches off.
                if (status.kind == KIND_FREE) begin
                    state_next = ST_FREE_CHECK;
                end else begin
                    priority if (status.ptr_end) begin
                        cmd.no_free = 1'b1;
                        state_next  = ST_FINISH;
                    end else if (status.word_hit) begin
                        cmd.take   = 1'b1;
                        state_next = ST_ALLOC_MUL;
                    end else begin
                        cmd.scan_step = 1'b1;
                    end
                end
            end
            ST_ALLOC_MUL: begin
                cmd.mul_addr = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FREE_CHECK: begin
                if (status.range_err) begin
                    cmd.range_flag = 1'b1;
                    state_next     = ST_FLAG_SCAN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_FREE_DIV;
                end
            end
            ST_FREE_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FREE_SET;
                end
            end
            ST_FREE_SET: begin
                cmd.set_bit = 1'b1;
                state_next  = ST_FLAG_SCAN;
            end
            ST_FLAG_SCAN: begin
                // Stop at the first word in use that is not entirely free.
                priority if (status.ptr_end) begin
                    state_next = ST_FINISH;
                end else if (!status.word_full) begin
                    cmd.not_all_free = 1'b1;
                    state_next       = ST_FINISH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid follows the result register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.result_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/core/bba_datapath.sv -----
// ----------------------------------------------------------------------------
// bba_datapath
// Datapath of the allocator: configuration registers, the free bitmap kept
// as words of eight blocks, the address multiplier, the restoring divider
// for free addresses and the result registers.
// ----------------------------------------------------------------------------
module bba_datapath
    import bba_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_kind,
    input  logic [ADDR_W-1:0]     s_free_address,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ADDR_W-1:0]     m_block_address,
    output logic [IDX_W-1:0]      m_block_index,
    output logic                  m_all_free
);

    // Configuration registers.
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;

    // Free bitmap, one bit per block, set means free.
    logic [WORD_W-1:0]  map_reg [WORDS];

    // Transaction state.
    logic               kind_reg;
    logic [PTR_W-1:0]   ptr_reg;
    logic [ADDR_W-1:0]  diff_reg;
    logic               below_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   dsr_reg;
    logic [IDX_W-1:0]   quot_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STATUS_W-1:0] stat_reg;
    logic [ADDR_W-1:0]  baddr_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               allfree_reg;

    // Result registers.
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_block_address_reg;
    logic [IDX_W-1:0]    m_block_index_reg;
    logic                m_all_free_reg;

    logic [NWR_W-1:0]           count_round;
    logic [PTR_W-1:0]           words_in_use;
    logic [SIZE_W-1:0]          size_eff;
    logic [PTR_W+BIT_W-1:0]     blocks_in_use;
    logic [WIDX_W-1:0]          ptr_idx;
    logic [WORD_W-1:0]          cur_word;
    logic [BIT_W-1:0]           first_pos;
    logic [IDX_W+SIZE_W-1:0]    offset;
    logic                       div_ge;

    // Lowest set bit of a bitmap word.
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

    // Blocks in use: count rounded up to whole words and capped at the pool.
    assign count_round   = NWR_W'((COUNT_W + 1)'({1'b0, count_reg} + (COUNT_W + 1)'(GROUP - 1))
                                  >> BIT_W);
    assign words_in_use  = (count_round > NWR_W'(WORDS)) ? PTR_W'(WORDS)
                                                          : count_round[PTR_W-1:0];
    assign blocks_in_use = {words_in_use, {BIT_W{1'b0}}};
    assign size_eff      = (size_reg == '0) ? SIZE_W'(1) : size_reg;

    // Word under the scan pointer.
    assign ptr_idx   = ptr_reg[WIDX_W-1:0];
    assign cur_word  = map_reg[ptr_idx];
    assign first_pos = lowest_set(cur_word);

    // Offset of the granted block from the pool base.
    assign offset = (IDX_W + SIZE_W)'(idx_reg) * (IDX_W + SIZE_W)'(size_eff);

    // One restoring-division step.
    assign div_ge = (rem_reg >= dsr_reg);

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            size_reg  <= SIZE_W'(16);
            count_reg <= COUNT_W'(MAX_BLOCKS);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_reg  <= cfg_data[ADDR_W-1:0];
                CFG_BLOCK_SIZE:   size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_BLOCK_COUNT:  count_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Bitmap updates: clear on a grant, set on a free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WORDS; i++) begin
                map_reg[i] <= '1;
            end
        end else if (cmd.take) begin
            map_reg[ptr_idx] <= cur_word & ~(WORD_W'(1) << first_pos);
        end else if (cmd.set_bit) begin
            map_reg[quot_reg[IDX_W-1:BIT_W]][quot_reg[BIT_W-1:0]] <= 1'b1;
        end
    end

    // Request capture, scan pointer and range check operands.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg  <= s_kind;
            diff_reg  <= s_free_address - base_reg;
            below_reg <= (s_free_address < base_reg);
            prod_reg  <= PROD_W'(size_eff) * PROD_W'(blocks_in_use);
        end
        if (cmd.capture) begin
            ptr_reg <= '0;
        end else if (cmd.scan_step) begin
            ptr_reg <= ptr_reg + PTR_W'(1);
        end
    end

    // Restoring divider, one quotient bit per cycle, most significant first.
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg  <= diff_reg[REM_W-1:0];
            dsr_reg  <= REM_W'({size_eff, {(IDX_W - 1){1'b0}}});
            quot_reg <= '0;
            step_reg <= STEP_W'(IDX_W - 1);
        end else if (cmd.div_step) begin
            if (div_ge) begin
                rem_reg <= rem_reg - dsr_reg;
            end
            quot_reg <= {quot_reg[IDX_W-2:0], div_ge};
            dsr_reg  <= dsr_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // Result staging.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            stat_reg    <= STATUS_DONE;
            baddr_reg   <= '0;
            idx_reg     <= '0;
            allfree_reg <= 1'b1;
        end else begin
            if (cmd.take) begin
                idx_reg     <= {ptr_idx, first_pos};
                allfree_reg <= 1'b0;
            end
            if (cmd.no_free) begin
                stat_reg    <= STATUS_NO_FREE;
                allfree_reg <= (words_in_use == '0);
            end
            if (cmd.mul_addr) begin
                baddr_reg <= base_reg + ADDR_W'(offset);
            end
            if (cmd.range_flag) begin
                stat_reg <= STATUS_RANGE;
            end
            if (cmd.set_bit) begin
                idx_reg <= quot_reg;
            end
            if (cmd.not_all_free) begin
                allfree_reg <= 1'b0;
            end
        end
    end

    // Output register, loaded once the previous result has been taken.
    always_ff @(posedge aclk) begin
        if (cmd.result_load) begin
            m_status_reg        <= stat_reg;
            m_block_address_reg <= baddr_reg;
            m_block_index_reg   <= idx_reg;
            m_all_free_reg      <= allfree_reg;
        end
    end

    assign status.kind      = kind_reg;
    assign status.word_hit  = (cur_word != '0);
    assign status.word_full = (cur_word == '1);
    assign status.ptr_end   = (ptr_reg == words_in_use);
    assign status.range_err = below_reg || (diff_reg >= ADDR_W'(prod_reg));
    assign status.div_last  = (step_reg == '0);

    assign m_status        = m_status_reg;
    assign m_block_address = m_block_address_reg;
    assign m_block_index   = m_block_index_reg;
    assign m_all_free      = m_all_free_reg;

endmodule

// ----- rtl/core/bitmap_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// Fixed-size block allocator over a free bitmap with a lowest-free-first
// policy, a range-checked free path and an all-free indication.
// ----------------------------------------------------------------------------
// One transaction is processed at a time. An allocate scans the bitmap words
// in use (block count rounded up to eight, divided by eight, at most 32):
// the scan reads one word of eight blocks per cycle, then the block address
// is formed as base plus index times block size. A free first checks the
// address against the pool; if it is in range, a restoring divider turns
// the offset into a block index. A second word-per-cycle scan of the bitmap
// then decides the all-free flag, stopping at the first word in use that is
// not entirely free. A result waits in the output register, so the next
// request can be accepted while it is still pending. Configuration writes
// are taken in every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
    import bba_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Request channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [ADDR_W-1:0]     s_free_address,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ADDR_W-1:0]     m_block_address,
    output logic [IDX_W-1:0]      m_block_index,
    output logic                  m_all_free
);

`include "assert_macros.svh"

    dp_cmd_t    cmd;
    dp_status_t status;

    // Result-side conditions for the failed-allocation check.
    logic       m_no_free;
    logic       m_fields_zero;

    // Configuration registers accept a write in every cycle.
    assign cfg_ready = 1'b1;

    // Sequencing.
    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Storage and arithmetic.
    bba_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_kind          (s_kind),
        .s_free_address  (s_free_address),
        .cmd             (cmd),
        .status          (status),
        .m_status        (m_status),
        .m_block_address (m_block_address),
        .m_block_index   (m_block_index),
        .m_all_free      (m_all_free)
    );

    assign m_no_free     = m_valid && (m_status == STATUS_NO_FREE);
    assign m_fields_zero = (m_block_address == '0) && (m_block_index == '0);

    // An accepted request keeps the block busy for at least the next cycle.
    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A new result is only loaded when the output register is free.
    `ASSERT_IMPL(a_no_result_overwrite, aclk, aresetn, cmd.result_load, !m_valid || m_ready)

    // A failed allocation reports neither an address nor an index.
    `ASSERT_IMPL(a_no_free_zero_fields, aclk, aresetn, m_no_free, m_fields_zero)

endmodule
